// File: design/ttg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared types, constants and helpers for the triangle tangent generator.
// ----------------------------------------------------------------------------
package ttg_pkg;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Number of quotient bits the divider develops one at a time.
  localparam int DIV_QBITS = 34;

  // One vertex as it arrives.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } vtx_t;

  // One triangle, reduced to its edges and texture coordinate deltas.
  typedef struct packed {
    logic signed [31:0] du1;
    logic signed [31:0] dv1;
    logic signed [31:0] du2;
    logic signed [31:0] dv2;
    logic signed [31:0] e1_x;
    logic signed [31:0] e2_x;
    logic signed [31:0] e1_y;
    logic signed [31:0] e2_y;
    logic signed [31:0] e1_z;
    logic signed [31:0] e2_z;
  } job_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_ITER,
    DIV_DONE
  } div_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_START,
    BK_DIV_WAIT,
    BK_OUT
  } back_state_e;

  // Returns b - a, saturated to the signed 32-bit range.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(b) - 33'(a);
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

endpackage

// File: design/ttg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_queue
// Short queue of triangle jobs between the front and the back.
// ----------------------------------------------------------------------------
module ttg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttg_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ttg_pkg::job_t data_o
);

  localparam int PW = $clog2(ttg_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(ttg_pkg::QUEUE_DEPTH + 1);

  ttg_pkg::job_t mem_q [ttg_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(ttg_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Storage is written only when a word is pushed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(ttg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(ttg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/ttg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_front
// Takes vertices, holds the first two corners and forms the edge job.
// ----------------------------------------------------------------------------
module ttg_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ttg_pkg::vtx_t      vtx_i,
  input  logic               final_vertex_i,
  output logic               push_o,
  output ttg_pkg::job_t      job_o,
  input  logic               full_i
);

  ttg_pkg::vtx_t hold_q [2];
  logic [1:0]    phase_q, phase_d;
  logic          accept;
  logic          third;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign third      = (phase_q == 2'd2);
  assign push_o     = accept && third;

  // Edges and texture deltas relative to corner 0, all saturated.
  always_comb begin
    job_o.du1  = ttg_pkg::sat_sub(hold_q[0].u, hold_q[1].u);
    job_o.dv1  = ttg_pkg::sat_sub(hold_q[0].v, hold_q[1].v);
    job_o.du2  = ttg_pkg::sat_sub(hold_q[0].u, vtx_i.u);
    job_o.dv2  = ttg_pkg::sat_sub(hold_q[0].v, vtx_i.v);
    job_o.e1_x = ttg_pkg::sat_sub(hold_q[0].x, hold_q[1].x);
    job_o.e2_x = ttg_pkg::sat_sub(hold_q[0].x, vtx_i.x);
    job_o.e1_y = ttg_pkg::sat_sub(hold_q[0].y, hold_q[1].y);
    job_o.e2_y = ttg_pkg::sat_sub(hold_q[0].y, vtx_i.y);
    job_o.e1_z = ttg_pkg::sat_sub(hold_q[0].z, hold_q[1].z);
    job_o.e2_z = ttg_pkg::sat_sub(hold_q[0].z, vtx_i.z);
  end

  // Corner counter; a final vertex always starts a fresh triangle.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        2'd0:    phase_d = 2'd1;
        2'd1:    phase_d = 2'd2;
        default: phase_d = 2'd0;
      endcase
      if (final_vertex_i) begin
        phase_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Corners 0 and 1 are held for the third vertex.
  always_ff @(posedge clk_i) begin
    if (accept && !third) begin
      hold_q[phase_q[0]] <= vtx_i;
    end
  end

endmodule

// File: design/ttg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_div
// Bit-serial signed divider giving num * 2^FRAC_BITS / den, saturated.
// ----------------------------------------------------------------------------
module ttg_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [64:0] num_i,
  input  logic signed [64:0] den_i,
  output logic               done_o,
  output logic [31:0]        quo_o
);

  localparam int QB = ttg_pkg::DIV_QBITS;
  localparam int DW = 65 + FRAC_BITS;
  localparam int TW = DW - QB;
  localparam int CW = $clog2(QB);

  ttg_pkg::div_state_e state_q, state_d;
  logic [64:0]   mn_q, md_q, rem_q;
  logic          neg_q, big_q;
  logic [QB-1:0] q_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd;
  logic [TW-1:0] top;
  logic [QB-1:0] low;
  logic [65:0]   r2;
  logic          ge;

  assign dvd = {mn_q, FRAC_BITS'(0)};
  assign top = dvd[DW-1:QB];
  assign low = dvd[QB-1:0];
  assign r2  = {rem_q, low[cnt_q]};
  assign ge  = (r2 >= {1'b0, md_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttg_pkg::DIV_IDLE:  if (start_i) state_d = ttg_pkg::DIV_CHECK;
      ttg_pkg::DIV_CHECK: state_d = ttg_pkg::DIV_ITER;
      ttg_pkg::DIV_ITER:  if (cnt_q == '0) state_d = ttg_pkg::DIV_DONE;
      ttg_pkg::DIV_DONE:  state_d = ttg_pkg::DIV_IDLE;
      default:            state_d = ttg_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttg_pkg::DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: magnitudes, overflow check on the upper dividend, then one
  // quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ttg_pkg::DIV_IDLE: begin
        mn_q  <= num_i[64] ? 65'(-num_i) : num_i;
        md_q  <= den_i[64] ? 65'(-den_i) : den_i;
        neg_q <= num_i[64] ^ den_i[64];
      end
      ttg_pkg::DIV_CHECK: begin
        big_q <= (65'(top) >= md_q);
        rem_q <= 65'(top);
        q_q   <= '0;
        cnt_q <= CW'(QB - 1);
      end
      ttg_pkg::DIV_ITER: begin
        rem_q <= ge ? 65'(r2 - {1'b0, md_q}) : r2[64:0];
        q_q   <= {q_q[QB-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    done_o = (state_q == ttg_pkg::DIV_DONE);
    if (neg_q) begin
      if (big_q || (q_q > QB'(33'h0_8000_0000))) begin
        quo_o = 32'h8000_0000;
      end else begin
        quo_o = 32'(QB'(0) - q_q);
      end
    end else begin
      if (big_q || (q_q > QB'(32'h7fff_ffff))) begin
        quo_o = 32'h7fff_ffff;
      end else begin
        quo_o = q_q[31:0];
      end
    end
  end

endmodule

// File: design/ttg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_back
// Works out one tangent per job and delivers it once for each corner.
// ----------------------------------------------------------------------------
module ttg_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ttg_pkg::job_t      q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         corner_o,
  output logic signed [31:0] tan_x_o,
  output logic signed [31:0] tan_y_o,
  output logic signed [31:0] tan_z_o,
  output logic               degenerate_o,
  output logic               last_of_triangle_o
);

  ttg_pkg::back_state_e state_q, state_d;
  ttg_pkg::job_t        job_q;
  logic                 div_start;
  logic                 div_done;
  logic [3:0]           cnt_q;
  logic [2:0]           slot;
  logic signed [31:0]   op_a, op_b;
  logic signed [63:0]   prod;
  logic signed [63:0]   p_q, first_q;
  logic signed [64:0]   res_q [4];
  logic [1:0]           comp_q, k_q;
  logic signed [31:0]   tan_q [3];
  logic                 degen_q;
  logic                 det_zero;
  logic                 out_load;
  logic [31:0]          quo;

  assign slot     = cnt_q[2:0] - 3'd1;
  assign det_zero = (res_q[0] == '0);
  assign out_load = (state_q == ttg_pkg::BK_OUT) && (!out_valid_o || !out_stall_i);
  assign q_pop_o  = (state_q == ttg_pkg::BK_IDLE) && q_valid_i;

  // Products in order: determinant pair, then x, y and z numerator pairs.
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    op_a = job_q.du1;
      3'd1:    op_a = job_q.du2;
      3'd2:    op_a = job_q.e1_x;
      3'd3:    op_a = job_q.e2_x;
      3'd4:    op_a = job_q.e1_y;
      3'd5:    op_a = job_q.e2_y;
      3'd6:    op_a = job_q.e1_z;
      default: op_a = job_q.e2_z;
    endcase
    op_b = cnt_q[0] ? job_q.dv1 : job_q.dv2;
  end

  assign prod = op_a * op_b;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttg_pkg::BK_IDLE: if (q_valid_i) state_d = ttg_pkg::BK_MUL;
      ttg_pkg::BK_MUL:  if (cnt_q == 4'd8) state_d = ttg_pkg::BK_DIV_START;
      ttg_pkg::BK_DIV_START: begin
        state_d = det_zero ? ttg_pkg::BK_OUT : ttg_pkg::BK_DIV_WAIT;
      end
      ttg_pkg::BK_DIV_WAIT: begin
        if (div_done) begin
          state_d = (comp_q == 2'd2) ? ttg_pkg::BK_OUT : ttg_pkg::BK_DIV_START;
        end
      end
      ttg_pkg::BK_OUT: if (out_load && k_q == 2'd2) state_d = ttg_pkg::BK_IDLE;
      default: state_d = ttg_pkg::BK_IDLE;
    endcase
  end

  // Divider control.
  always_comb begin
    div_start = (state_q == ttg_pkg::BK_DIV_START) && !det_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttg_pkg::BK_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Multiply sequence, tangent collection and output word.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ttg_pkg::BK_IDLE: begin
        job_q  <= q_data_i;
        cnt_q  <= 4'd0;
        comp_q <= 2'd0;
        k_q    <= 2'd0;
      end
      ttg_pkg::BK_MUL: begin
        cnt_q <= cnt_q + 1'b1;
        if (!cnt_q[3]) begin
          p_q <= prod;
        end
        if (cnt_q != 4'd0) begin
          if (!slot[0]) begin
            first_q <= p_q;
          end else begin
            res_q[slot[2:1]] <= 65'(first_q) - 65'(p_q);
          end
        end
      end
      ttg_pkg::BK_DIV_START: begin
        degen_q <= det_zero;
        if (det_zero) begin
          tan_q[0] <= '0;
          tan_q[1] <= '0;
          tan_q[2] <= '0;
        end
      end
      ttg_pkg::BK_DIV_WAIT: begin
        if (div_done) begin
          tan_q[comp_q] <= quo;
          comp_q        <= comp_q + 1'b1;
        end
      end
      ttg_pkg::BK_OUT: begin
        if (out_load) begin
          corner_o           <= k_q;
          tan_x_o            <= tan_q[0];
          tan_y_o            <= tan_q[1];
          tan_z_o            <= tan_q[2];
          degenerate_o       <= degen_q;
          last_of_triangle_o <= (k_q == 2'd2);
          k_q                <= k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  ttg_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (res_q[comp_q + 2'd1]),
    .den_i  (res_q[0]),
    .done_o (div_done),
    .quo_o  (quo)
  );

endmodule

// File: design/triangle_tangent_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_generator_unit
// Per-triangle tangent from positions and texture coordinates.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i/in_stall_o  | pos_x/y/z, tex_u/v, final_vertex
//  out     | output    | out_valid_o/out_stall_i| corner, tan_x/y/z, degenerate, last
//
//  Vertices are taken one per cycle until the job queue is full.
//  In the back part a triangle goes through the shared multiplier and then,
//  unless its determinant is zero, through the bit-serial divider for each
//  of the three components; no new job is taken until all three corners are out.
//  Reset clears the corner count, the queue and the output valid flag.
//  A stalled output holds its word; the front takes vertices till the queue fills.
// ----------------------------------------------------------------------------
module triangle_tangent_generator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_i,
  input  logic               final_vertex_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         corner_o,
  output logic signed [31:0] tan_x_o,
  output logic signed [31:0] tan_y_o,
  output logic signed [31:0] tan_z_o,
  output logic               degenerate_o,
  output logic               last_of_triangle_o
);

  ttg_pkg::vtx_t vtx;
  ttg_pkg::job_t push_job, pop_job;
  logic          push, full, pop, q_valid;

  assign vtx.x = pos_x_i;
  assign vtx.y = pos_y_i;
  assign vtx.z = pos_z_i;
  assign vtx.u = tex_u_i;
  assign vtx.v = tex_v_i;

  ttg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vtx_i         (vtx),
    .final_vertex_i(final_vertex_i),
    .push_o        (push),
    .job_o         (push_job),
    .full_i        (full)
  );

  ttg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (pop_job)
  );

  ttg_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (pop_job),
    .q_pop_o           (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .corner_o          (corner_o),
    .tan_x_o           (tan_x_o),
    .tan_y_o           (tan_y_o),
    .tan_z_o           (tan_z_o),
    .degenerate_o      (degenerate_o),
    .last_of_triangle_o(last_of_triangle_o)
  );

endmodule
